@@ rtl/flr_pkg.sv @@
// Package with constants and types shared by the frame line reassembly tracker files.
package flr_pkg;

    localparam int MAX_LINES = 512;
    localparam int ROW_W     = 16;
    localparam int ROW_SH    = $clog2(ROW_W);
    localparam int ROWS      = (MAX_LINES + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [9:0]  LINE_COUNT_RESET = 10'd500;
    localparam logic [19:0] WAIT_TICKS_RESET = 20'd1000;

    localparam logic REG_LINE_COUNT = 1'b0;
    localparam logic REG_WAIT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_LINE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        V_ACCEPT      = 3'd0,
        V_WRONG_FRAME = 3'd1,
        V_RANGE       = 3'd2,
        V_DUP         = 3'd3,
        V_IDLE        = 3'd4,
        V_CONTROL     = 3'd5
    } verdict_t;

endpackage

@@ rtl/frame_line_reassembly_tracker.sv @@
// Top level of the frame line reassembly tracker.
// The block takes one word per cycle and returns one result word for each, after the word has
// passed the working register and the output register; back-pressure on the result side stalls
// the input only when both these registers are full. The rate is set by the line-presence map,
// a registered-read RAM of rows of 16 flags that is read when a word is accepted and written
// back from the working register, with a forwarding register for back-to-back hits on one row.
// A start clears the map at once through one valid flag per row, so there is no clearing
// pass after reset. Registers line_count (offset 0) and wait_ticks (offset 4) sit on the
// APB port and are sampled live; write them only while no word is in flight.
module frame_line_reassembly_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: frame_number[15:0], line_number[31:16]
    input  logic [31:0] s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: verdict[2:0], line_slot[11:3], frame_started[12], frame_id[20:13],
    // frame_done[21], missing_lines[31:22], timed_out[32], zero fill[39:33]
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import flr_pkg::*;

    logic [9:0]  line_count_reg;
    logic [19:0] wait_ticks_reg;

    logic        p_valid_reg;
    opcode_t     p_op_reg;
    logic [15:0] p_fnum_reg;
    logic [15:0] p_lnum_reg;

    logic             fwd_hit_reg;
    logic [ROW_W-1:0] fwd_data_reg;
    logic [ROWS-1:0]  row_valid_reg, row_valid_next;

    logic [9:0]  lines_remaining_reg, lines_remaining_next;
    logic [7:0]  frame_counter_reg, frame_counter_next;
    logic        request_open_reg, request_open_next;
    logic [19:0] timeout_counter_reg, timeout_counter_next;

    logic        m_valid_reg;
    logic [32:0] m_data_reg;

    logic        p_fire, s_accept, cfg_write;
    logic [15:0] s_idx, p_idx;
    logic [ROW_AW-1:0] s_row, p_row;
    logic [ROW_SH-1:0] p_bit;
    logic [ROW_W-1:0]  ram_rdata, old_row, row_wdata;
    logic        wr_en;
    logic [9:0]  eff_lines;

    verdict_t    verdict;
    logic [8:0]  slot;
    logic        started, done, tmo;
    logic [9:0]  missing;

    assign p_fire   = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || p_fire;
    assign s_accept = s_tvalid && s_tready;

    assign s_idx = s_tdata[31:16] - 16'd1;
    assign s_row = s_idx[ROW_SH +: ROW_AW];
    assign p_idx = p_lnum_reg - 16'd1;
    assign p_row = p_idx[ROW_SH +: ROW_AW];
    assign p_bit = p_idx[ROW_SH-1:0];

    flr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map (
        .aclk  (aclk),
        .we    (p_fire && wr_en),
        .waddr (p_row),
        .wdata (row_wdata),
        .re    (s_accept),
        .raddr (s_row),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (line_count_reg == 10'd0) begin
            eff_lines = 10'd1;
        end else if (32'(line_count_reg) > 32'(MAX_LINES)) begin
            eff_lines = 10'(MAX_LINES);
        end else begin
            eff_lines = line_count_reg;
        end
    end

    always_comb begin
        if (fwd_hit_reg) begin
            old_row = fwd_data_reg;
        end else if (row_valid_reg[p_row]) begin
            old_row = ram_rdata;
        end else begin
            old_row = '0;
        end
        row_wdata = old_row | (ROW_W'(1) << p_bit);
    end

    always_comb begin
        verdict              = V_CONTROL;
        slot                 = 9'd0;
        started              = 1'b0;
        done                 = 1'b0;
        missing              = 10'd0;
        tmo                  = 1'b0;
        wr_en                = 1'b0;
        row_valid_next       = row_valid_reg;
        lines_remaining_next = lines_remaining_reg;
        frame_counter_next   = frame_counter_reg;
        request_open_next    = request_open_reg;
        timeout_counter_next = timeout_counter_reg;
        case (p_op_reg)
            OP_START: begin
                if (!request_open_reg) begin
                    frame_counter_next   = frame_counter_reg + 8'd1;
                    row_valid_next       = '0;
                    lines_remaining_next = eff_lines;
                    timeout_counter_next = wait_ticks_reg;
                    request_open_next    = 1'b1;
                    started              = 1'b1;
                end
            end
            OP_LINE: begin
                if (!request_open_reg) begin
                    verdict = V_IDLE;
                end else if (p_fnum_reg != {8'd0, frame_counter_reg}) begin
                    verdict = V_WRONG_FRAME;
                end else if (p_lnum_reg == 16'd0 || p_lnum_reg > {6'd0, eff_lines}) begin
                    verdict = V_RANGE;
                end else if (old_row[p_bit]) begin
                    verdict = V_DUP;
                end else begin
                    verdict               = V_ACCEPT;
                    slot                  = p_idx[8:0];
                    wr_en                 = 1'b1;
                    row_valid_next[p_row] = 1'b1;
                    if (lines_remaining_reg != 10'd0) begin
                        lines_remaining_next = lines_remaining_reg - 10'd1;
                    end
                    if (lines_remaining_next == 10'd0) begin
                        request_open_next = 1'b0;
                        done              = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (request_open_reg) begin
                    if (timeout_counter_reg <= 20'd1) begin
                        timeout_counter_next = 20'd0;
                        request_open_next    = 1'b0;
                        done                 = 1'b1;
                        missing              = lines_remaining_reg;
                        tmo                  = (lines_remaining_reg != 10'd0);
                    end else begin
                        timeout_counter_next = timeout_counter_reg - 20'd1;
                    end
                end
            end
            OP_STOP: begin
                if (request_open_reg) begin
                    request_open_next    = 1'b0;
                    timeout_counter_next = 20'd0;
                    done                 = 1'b1;
                    missing              = lines_remaining_reg;
                    tmo                  = (lines_remaining_reg != 10'd0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg         <= 1'b0;
            fwd_hit_reg         <= 1'b0;
            row_valid_reg       <= '0;
            lines_remaining_reg <= 10'd0;
            frame_counter_reg   <= 8'd0;
            request_open_reg    <= 1'b0;
            timeout_counter_reg <= 20'd0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (s_accept) begin
                p_valid_reg <= 1'b1;
                fwd_hit_reg <= p_fire && wr_en && (p_row == s_row);
            end else if (p_fire) begin
                p_valid_reg <= 1'b0;
            end
            if (p_fire) begin
                row_valid_reg       <= row_valid_next;
                lines_remaining_reg <= lines_remaining_next;
                frame_counter_reg   <= frame_counter_next;
                request_open_reg    <= request_open_next;
                timeout_counter_reg <= timeout_counter_next;
                m_valid_reg         <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_op_reg     <= opcode_t'(s_tuser);
            p_fnum_reg   <= s_tdata[15:0];
            p_lnum_reg   <= s_tdata[31:16];
            fwd_data_reg <= row_wdata;
        end
        if (p_fire) begin
            m_data_reg <= {tmo, missing, done, frame_counter_next, started, slot, verdict};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= LINE_COUNT_RESET;
            wait_ticks_reg <= WAIT_TICKS_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_LINE_COUNT: line_count_reg <= pwdata[9:0];
                REG_WAIT_TICKS: wait_ticks_reg <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LINE_COUNT: prdata = {22'd0, line_count_reg};
            REG_WAIT_TICKS: prdata = {12'd0, wait_ticks_reg};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/flr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module flr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ dv/tb_frame_line_reassembly_tracker.sv @@
// Self-checking testbench for the frame line reassembly tracker: directed and random words with a scoreboard.
`timescale 1ns / 100ps

import flr_pkg::*;

typedef struct packed {
    logic [6:0]  fill;
    logic        timed_out;
    logic [9:0]  missing;
    logic        done;
    logic [7:0]  id;
    logic        started;
    logic [8:0]  slot;
    verdict_t    verdict;
} line_verdict_t;

class flr_scoreboard;
    logic [9:0]           line_count;
    logic [19:0]          wait_ticks;
    logic [MAX_LINES-1:0] present;
    logic [9:0]           lines_left;
    logic [7:0]           frame_id;
    logic                 frame_open;
    logic [19:0]          ticks_left;
    line_verdict_t        verdicts_due[$];
    int unsigned          failures;

    function new();
        line_count = LINE_COUNT_RESET;
        wait_ticks = WAIT_TICKS_RESET;
        present    = '0;
        lines_left = '0;
        frame_id   = '0;
        frame_open = 1'b0;
        ticks_left = '0;
        failures   = 0;
    endfunction

    function int unsigned eff_lines();
        int unsigned n;
        n = line_count;
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_LINES) begin
            n = MAX_LINES;
        end
        return n;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
        if (idx == REG_LINE_COUNT) begin
            line_count = value[9:0];
        end else begin
            wait_ticks = value[19:0];
        end
    endfunction

    function void close_frame(ref line_verdict_t r);
        frame_open  = 1'b0;
        ticks_left  = '0;
        r.done      = 1'b1;
        r.missing   = lines_left;
        r.timed_out = (lines_left != 0);
    endfunction

    function void note_word(opcode_t op, logic [15:0] fnum, logic [15:0] lnum);
        line_verdict_t r;
        int unsigned   idx;
        r = '0;
        r.verdict = V_CONTROL;
        case (op)
            OP_START: begin
                if (!frame_open) begin
                    frame_id   = frame_id + 8'd1;
                    present    = '0;
                    lines_left = 10'(eff_lines());
                    ticks_left = wait_ticks;
                    frame_open = 1'b1;
                    r.started  = 1'b1;
                end
            end
            OP_LINE: begin
                if (!frame_open) begin
                    r.verdict = V_IDLE;
                end else if (fnum != {8'h00, frame_id}) begin
                    r.verdict = V_WRONG_FRAME;
                end else if (lnum == 0 || lnum > eff_lines()) begin
                    r.verdict = V_RANGE;
                end else begin
                    idx = lnum - 1;
                    if (present[idx]) begin
                        r.verdict = V_DUP;
                    end else begin
                        r.verdict    = V_ACCEPT;
                        r.slot       = idx[8:0];
                        present[idx] = 1'b1;
                        if (lines_left > 0) begin
                            lines_left = lines_left - 10'd1;
                        end
                        if (lines_left == 0) begin
                            frame_open = 1'b0;
                            r.done     = 1'b1;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (frame_open) begin
                    if (ticks_left <= 1) begin
                        close_frame(r);
                    end else begin
                        ticks_left = ticks_left - 20'd1;
                    end
                end
            end
            default: begin
                if (frame_open) begin
                    close_frame(r);
                end
            end
        endcase
        r.id = frame_id;
        verdicts_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    function void check_word(logic [39:0] word);
        line_verdict_t act;
        line_verdict_t exp;
        if (verdicts_due.size() == 0) begin
            $display("%0t: result word %h arrived with nothing expected", $time, word);
            failures++;
            return;
        end
        act = line_verdict_t'(word);
        exp = verdicts_due.pop_front();
        compare_field("verdict", exp.verdict, act.verdict);
        compare_field("line_slot", exp.slot, act.slot);
        compare_field("frame_started", exp.started, act.started);
        compare_field("frame_id", exp.id, act.id);
        compare_field("frame_done", exp.done, act.done);
        compare_field("missing_lines", exp.missing, act.missing);
        compare_field("timed_out", exp.timed_out, act.timed_out);
        compare_field("zero fill", exp.fill, act.fill);
    endfunction
endclass

module tb_frame_line_reassembly_tracker;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // tdata: frame_number[15:0], line_number[31:16]
    logic [31:0] s_tdata;
    // tuser: opcode[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tdata: verdict, line_slot, frame_started, frame_id, frame_done, missing_lines, timed_out
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flr_scoreboard sb = new();
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            rx_stall_left = 0;
    int            idle_cycles = 0;

    frame_line_reassembly_tracker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready      <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(1, 12) - 1;
            m_tready      <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata);
        end
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("frame_line_reassembly_tracker regression: fail");
        $finish;
    end

    task automatic send_word(opcode_t op, logic [15:0] fnum, logic [15:0] lnum);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {lnum, fnum};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_word(op, fnum, lnum);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_item();
        int unsigned roll;
        opcode_t     op;
        logic [15:0] f;
        logic [15:0] l;
        roll = $urandom_range(0, 99);
        op   = opcode_t'($urandom_range(0, 3));
        f    = 16'($urandom);
        l    = 16'($urandom);
        if (!sb.frame_open) begin
            if (roll < 65) begin
                op = OP_START;
            end
        end else if (roll < 55) begin
            op = OP_LINE;
            f  = {8'h00, sb.frame_id};
            l  = 16'($urandom_range(1, sb.eff_lines()));
        end else if (roll < 75) begin
            op = OP_TICK;
        end else if (roll < 78) begin
            op = OP_STOP;
        end else if (roll < 84) begin
            op = OP_LINE;
            f  = {8'h00, sb.frame_id};
            l  = (roll < 80) ? 16'd0 : 16'(sb.eff_lines() + $urandom_range(1, 8));
        end else if (roll < 88) begin
            op      = OP_LINE;
            f[7:0]  = sb.frame_id;
        end
        send_word(op, f, l);
    endtask

    initial begin
        logic [9:0]  lc;
        logic [19:0] wt;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_START;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(OP_LINE, 16'hFFFF, 16'hFFFF);
        send_word(OP_TICK, 16'h0000, 16'h0000);
        send_word(OP_STOP, 16'h0000, 16'h0000);
        send_word(OP_START, 16'h0000, 16'h0000);
        send_word(OP_START, 16'h0000, 16'h0000);
        send_word(OP_LINE, 16'd1, 16'd0);
        send_word(OP_LINE, 16'h0101, 16'd1);
        send_word(OP_LINE, 16'd1, 16'd1);
        send_word(OP_LINE, 16'd1, 16'd1);
        send_word(OP_LINE, 16'd1, 16'd500);
        send_word(OP_LINE, 16'd1, 16'd501);
        send_word(OP_STOP, 16'hFFFF, 16'hFFFF);
        wait_results();
        write_reg(REG_LINE_COUNT, 32'd0);
        write_reg(REG_WAIT_TICKS, 32'd0);
        send_word(OP_START, 16'h0000, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'h0000);
        send_word(OP_START, 16'h0000, 16'h0000);
        send_word(OP_LINE, 16'd3, 16'd2);
        send_word(OP_LINE, 16'd3, 16'd1);
        wait_results();
        write_reg(REG_LINE_COUNT, 32'd1023);
        write_reg(REG_WAIT_TICKS, 32'd1);
        send_word(OP_START, 16'h0000, 16'h0000);
        send_word(OP_LINE, 16'd4, 16'd512);
        send_word(OP_LINE, 16'd4, 16'd513);
        send_word(OP_TICK, 16'h0000, 16'h0000);
        wait_results();
        write_reg(REG_LINE_COUNT, 32'd2);
        write_reg(REG_WAIT_TICKS, 32'hFFFFF);
        send_word(OP_START, 16'h0000, 16'h0000);
        send_word(OP_TICK, 16'h0000, 16'h0000);
        send_word(OP_LINE, 16'd5, 16'd2);
        send_word(OP_LINE, 16'd5, 16'd1);
        send_word(OP_TICK, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                lc = 10'd1;
                wt = 20'd10;
            end else if (phase == 1) begin
                lc = 10'd512;
                wt = 20'hFFFFF;
            end else begin
                lc = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(1, 12)) : 10'($urandom);
                case ($urandom_range(0, 6))
                    0: wt = 20'($urandom_range(0, 1));
                    1: wt = 20'($urandom);
                    default: wt = 20'($urandom_range(10, 24));
                endcase
            end
            wait_results();
            tx_idle_on = (phase < 6) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase < 6) && ($urandom_range(0, 3) != 0);
            write_reg(REG_LINE_COUNT, {22'd0, lc});
            write_reg(REG_WAIT_TICKS, {12'd0, wt});
            repeat (100) random_item();
        end

        wait_results();
        repeat (8) @(posedge aclk);
        if (sb.failures == 0 && sb.verdicts_due.size() == 0) begin
            $display("frame_line_reassembly_tracker regression: pass");
        end else begin
            $display("%0t: %0d mismatches, %0d results still expected", $time, sb.failures,
                     sb.verdicts_due.size());
            $display("frame_line_reassembly_tracker regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/flr_pkg.sv
rtl/flr_ram.sv
rtl/frame_line_reassembly_tracker.sv
dv/tb_frame_line_reassembly_tracker.sv
